### hw/rtl/bdrm_pkg.sv
// Package for the byte difference run merger: widths, register indexes,
// reset values and the payload, configuration and state structs.
// No dependencies.
package bdrm_pkg;

  localparam int OFFSET_BITS = 25;
  localparam int OFF_W       = OFFSET_BITS;
  localparam int LEN_W       = OFFSET_BITS + 1;
  localparam int CFG_W       = 26;
  localparam int CFG_IDX_W   = 3;
  localparam int GAP_W       = 8;
  localparam int CTX_W       = 12;
  localparam int CNT_W       = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EXCLUDE_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXCLUDE_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MERGE_GAP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONTEXT_BYTES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_LENGTH  = 3'd5;

  // reset values
  localparam logic [GAP_W-1:0] MERGE_GAP_RST     = 8'd16;
  localparam logic [CTX_W-1:0] CONTEXT_BYTES_RST = 12'd128;
  localparam logic [CNT_W-1:0] REPORT_LIMIT_RST  = 8'd8;
  localparam logic [CNT_W-1:0] CNT_MAX           = {CNT_W{1'b1}};
  localparam logic [LEN_W-1:0] BYTES_MAX         = {LEN_W{1'b1}};

  typedef struct packed {
    logic             module_start;
    logic             section_first;
    logic             section_last;
    logic [OFF_W-1:0] byte_offset;
    logic [7:0]       mapped_byte;
    logic [7:0]       file_byte;
  } bdrm_in_t;

  typedef struct packed {
    logic [OFF_W-1:0] run_start;
    logic [LEN_W-1:0] run_length;
    logic [OFF_W-1:0] start_in_section;
    logic [OFF_W-1:0] context_start;
    logic [LEN_W-1:0] context_end;
    logic             reported;
    logic             first_in_module;
    logic [LEN_W-1:0] bytes_total;
  } bdrm_out_t;

  typedef struct packed {
    logic [CFG_W-1:0] exclude_low;
    logic [CFG_W-1:0] exclude_high;
    logic [GAP_W-1:0] merge_gap;
    logic [CTX_W-1:0] context_bytes;
    logic [CNT_W-1:0] report_limit;
    logic [CFG_W-1:0] image_length;
  } bdrm_cfg_t;

  typedef struct packed {
    logic             run_open;
    logic [OFF_W-1:0] open_start;
    logic [LEN_W-1:0] open_end;
    logic [LEN_W-1:0] open_len;
    logic [OFF_W-1:0] section_base;
    logic [CNT_W-1:0] run_count;
    logic             skipping;
    logic [LEN_W-1:0] module_bytes;
  } bdrm_state_t;

endpackage

### hw/rtl/byte_diff_run_merger.sv
// Top level of the byte difference run merger: handshakes, configuration
// registers and run state. Uses bdrm_pkg and bdrm_step.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one byte position per
//   request: offset, the mapped and file bytes, and section/module marks.
//   Result channel (out_valid/out_ready/out_data) carries one closed run per
//   request; most bytes produce none.
//   Config port (cfg_wr_en/cfg_index/cfg_data) writes a register; only
//   write it while the block is idle. Unused indexes are ignored.
//   Timing: an accepted request is held in the input register; when the
//   result slot is free the step logic updates run state and, if a run
//   closes, loads the result register, which raises out_valid.
//   Throughput: one byte position per cycle while the result slot is free,
//   set by the run state update in bdrm_step (state feeds straight back).
//   Receiver stall: while a result waits, the input register holds; one
//   further request is still taken into it before in_ready drops.
//   Reset (rst_n low, synchronous): run state and counters clear, the
//   registers return to their defaults, both valid flags drop.
module byte_diff_run_merger (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  bdrm_pkg::bdrm_in_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output bdrm_pkg::bdrm_out_t                   out_data,
  input  logic                                  cfg_wr_en,
  input  logic [bdrm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bdrm_pkg::CFG_W-1:0]            cfg_data
);

  bdrm_pkg::bdrm_cfg_t   cfg_r;
  bdrm_pkg::bdrm_state_t st_r;
  bdrm_pkg::bdrm_state_t st_nxt;
  bdrm_pkg::bdrm_in_t    item_r;
  bdrm_pkg::bdrm_out_t   res_nxt;
  bdrm_pkg::bdrm_out_t   out_r;
  logic                  item_vld_r;
  logic                  out_vld_r;
  logic                  close;
  logic                  go;

  // the step runs when an item is held and the result slot is free
  assign go       = item_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !item_vld_r || go;

  bdrm_step u_step (
    .cfg   (cfg_r),
    .cur   (st_r),
    .item  (item_r),
    .nxt   (st_nxt),
    .res   (res_nxt),
    .close (close)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.exclude_low   <= '0;
      cfg_r.exclude_high  <= '0;
      cfg_r.merge_gap     <= bdrm_pkg::MERGE_GAP_RST;
      cfg_r.context_bytes <= bdrm_pkg::CONTEXT_BYTES_RST;
      cfg_r.report_limit  <= bdrm_pkg::REPORT_LIMIT_RST;
      cfg_r.image_length  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bdrm_pkg::REG_EXCLUDE_LOW:   cfg_r.exclude_low   <= cfg_data;
        bdrm_pkg::REG_EXCLUDE_HIGH:  cfg_r.exclude_high  <= cfg_data;
        bdrm_pkg::REG_MERGE_GAP:     cfg_r.merge_gap     <= cfg_data[bdrm_pkg::GAP_W-1:0];
        bdrm_pkg::REG_CONTEXT_BYTES: cfg_r.context_bytes <= cfg_data[bdrm_pkg::CTX_W-1:0];
        bdrm_pkg::REG_REPORT_LIMIT:  cfg_r.report_limit  <= cfg_data[bdrm_pkg::CNT_W-1:0];
        bdrm_pkg::REG_IMAGE_LENGTH:  cfg_r.image_length  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ready) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_data;
    end
  end

  // run state, all fields cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (go) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (go) begin
      out_vld_r <= close;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && close) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // a new result only ever comes from a step
  a_result_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(go))
    else $error("result appeared without a step");

  // a closed run leaves no run open
  a_close_clears_open: assert property (@(posedge clk) disable iff (!rst_n)
    go && close |=> !st_r.run_open)
    else $error("run still open after close");

  // run count only falls at a module start
  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    go && !item_r.module_start |=> st_r.run_count >= $past(st_r.run_count))
    else $error("run count fell without module start");

  // running total always covers the run it includes
  a_total_covers_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> out_r.bytes_total >= out_r.run_length)
    else $error("byte total below run length");
`endif

endmodule

### hw/rtl/bdrm_step.sv
// One byte position of the run merger: next state and the closed-run request.
// Purely combinational; uses bdrm_pkg.
module bdrm_step (
  input  bdrm_pkg::bdrm_cfg_t   cfg,
  input  bdrm_pkg::bdrm_state_t cur,
  input  bdrm_pkg::bdrm_in_t    item,
  output bdrm_pkg::bdrm_state_t nxt,
  output bdrm_pkg::bdrm_out_t   res,
  output logic                  close
);

  localparam int OFF_W = bdrm_pkg::OFF_W;
  localparam int LEN_W = bdrm_pkg::LEN_W;
  localparam int CNT_W = bdrm_pkg::CNT_W;

  logic [CNT_W-1:0] cnt0;
  logic [LEN_W-1:0] mbytes0;
  logic             open0;
  logic             skip0;
  logic [OFF_W-1:0] base0;
  logic [LEN_W-1:0] off_ext;
  logic             excluded;
  logic             differs;
  logic [OFF_W-1:0] start1;
  logic [LEN_W-1:0] end1;
  logic [LEN_W-1:0] len1;
  logic             open1;
  logic             gap_close;
  logic [LEN_W:0]   gap_limit;
  logic [LEN_W:0]   hi;
  logic [LEN_W:0]   sum;
  logic [OFF_W-1:0] ctx_ext;

  always_comb begin
    // module start, then section start
    cnt0    = item.module_start ? '0 : cur.run_count;
    mbytes0 = item.module_start ? '0 : cur.module_bytes;
    open0   = cur.run_open & ~item.module_start & ~item.section_first;
    skip0   = item.section_first ? (cnt0 >= cfg.report_limit)
                                 : (cur.skipping & ~item.module_start);
    base0   = item.section_first ? item.byte_offset : cur.section_base;

    off_ext  = {1'b0, item.byte_offset};
    excluded = (off_ext >= cfg.exclude_low) && (off_ext < cfg.exclude_high);
    differs  = (item.mapped_byte != item.file_byte) && !excluded;

    gap_limit = {1'b0, cur.open_end} + {{(LEN_W + 1 - bdrm_pkg::GAP_W){1'b0}}, cfg.merge_gap};
    gap_close = 1'b0;
    if (differs) begin
      start1 = open0 ? cur.open_start : item.byte_offset;
      end1   = off_ext + LEN_W'(1);
      len1   = end1 - {1'b0, start1};
      open1  = 1'b1;
    end else begin
      start1    = cur.open_start;
      end1      = cur.open_end;
      len1      = cur.open_len;
      open1     = open0;
      gap_close = open0 && ({1'b0, off_ext} >= gap_limit);
    end

    close = !skip0 && (gap_close || (item.section_last && open1));

    // closed-run figures
    ctx_ext = {{(OFF_W - bdrm_pkg::CTX_W){1'b0}}, cfg.context_bytes};
    hi      = {1'b0, end1} + {{(LEN_W + 1 - bdrm_pkg::CTX_W){1'b0}}, cfg.context_bytes};
    sum     = {1'b0, mbytes0} + {1'b0, len1};

    res.run_start        = start1;
    res.run_length       = len1;
    res.start_in_section = start1 - base0;
    res.context_start    = (start1 > ctx_ext) ? (start1 - ctx_ext) : '0;
    res.context_end      = (hi > {1'b0, cfg.image_length}) ? cfg.image_length
                                                           : hi[LEN_W-1:0];
    res.reported         = cnt0 < cfg.report_limit;
    res.first_in_module  = cnt0 == '0;
    res.bytes_total      = sum[LEN_W] ? bdrm_pkg::BYTES_MAX : sum[LEN_W-1:0];

    // next state
    nxt.section_base = base0;
    nxt.skipping     = skip0;
    if (skip0) begin
      nxt.run_open     = open0;
      nxt.open_start   = cur.open_start;
      nxt.open_end     = cur.open_end;
      nxt.open_len     = cur.open_len;
      nxt.run_count    = cnt0;
      nxt.module_bytes = mbytes0;
    end else begin
      nxt.run_open     = open1 & ~close;
      nxt.open_start   = start1;
      nxt.open_end     = end1;
      nxt.open_len     = len1;
      nxt.run_count    = (close && cnt0 != bdrm_pkg::CNT_MAX) ? cnt0 + CNT_W'(1) : cnt0;
      nxt.module_bytes = close ? res.bytes_total : mbytes0;
    end
  end

endmodule
